// File: design/mawf_pkg.sv
// Shared constants and defaults for the moving-average window filter.
`timescale 1ns / 1ps

package mawf_pkg;

    localparam int MAX_WINDOW_DEF   = 128;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int         CFG_W        = 8;
    localparam logic [7:0] WINDOW_RESET = 8'd1;

endpackage

// File: design/moving_average_window_filter_core.sv
// Top level of the moving-average window filter: control, sample memory and running sum.
`timescale 1ns / 1ps

// A filtered item (tuser high) has its average formed by the bit-serial divider, which
// produces one quotient bit per cycle, and the next item can be taken in the same cycle
// as that average is presented. The window sum is kept as a running sum updated through
// one read-modify-write of the sample memory. After a pass-through item (tuser low), which
// floods the window with its sample, or after a write of the window length, the next
// filtered item first re-sums the window from the memory. Reset needs no clearing pass:
// a flood value register and a fill mark stand in for memory entries not yet written.
// The next item is taken while a result still waits at the output.
module moving_average_window_filter_core #(
    parameter int MAX_WINDOW   = mawf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = mawf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // s_axis_tdata: [SAMPLE_WIDTH-1:0] sample, zero fill above
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // s_axis_tuser: [0] enable
    input  logic                                    s_axis_tuser,
    // m_axis_tdata: [SAMPLE_WIDTH-1:0] average, zero fill above
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    input  logic                                    cfg_we,
    input  logic [mawf_pkg::CFG_W-1:0]              cfg_wdata
);
    import mawf_pkg::*;

    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W   = (WIN_W > CFG_W) ? WIN_W : CFG_W;
    localparam int SUM_W   = SAMPLE_WIDTH + WIN_W;
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                    state_reg,     state_next;
    logic [CFG_W-1:0]          win_len_reg,   win_len_next;
    logic [IDX_W-1:0]          wr_idx_reg,    wr_idx_next;
    logic [IDX_W-1:0]          fill_max_reg,  fill_max_next;
    logic                      zero_wr_reg,   zero_wr_next;
    logic [SAMPLE_WIDTH-1:0]   flood_reg,     flood_next;
    logic                      dirty_reg,     dirty_next;
    logic signed [SUM_W-1:0]   sum_reg,       sum_next;
    logic [WIN_W-1:0]          rd_cnt_reg,    rd_cnt_next;
    logic                      rd_pend_reg,   rd_pend_next;
    logic                      rd_valid_reg,  rd_valid_next;
    logic                      div_start_reg, div_start_next;
    logic                      m_valid_reg,   m_valid_next;
    logic [SAMPLE_WIDTH-1:0]   m_data_reg,    m_data_next;
    logic [SAMPLE_WIDTH-1:0]   res_reg,       res_next;
    logic [SAMPLE_WIDTH-1:0]   sample_reg,    sample_next;

    logic                      in_accept;
    logic [SAMPLE_WIDTH-1:0]   in_sample;
    logic [CMP_W-1:0]          cfg_ext;
    logic [CMP_W-1:0]          win_cmp;
    logic [WIN_W-1:0]          win;
    logic [WIN_W-1:0]          idx_inc;
    logic [IDX_W-1:0]          idx_new;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [SAMPLE_WIDTH-1:0]   ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [SAMPLE_WIDTH-1:0]   ram_rdata;
    logic [SAMPLE_WIDTH-1:0]   mem_val;
    logic signed [SUM_W-1:0]   mem_ext;
    logic signed [SUM_W-1:0]   smp_ext;
    logic                      out_free;
    logic                      div_done;
    logic signed [SAMPLE_WIDTH-1:0] div_quot;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign out_free  = !m_valid_reg || m_axis_tready;

    // The register keeps what was written; the clamp applies on every use.
    always_comb
    begin
        cfg_ext = CMP_W'(win_len_reg);
        priority if (cfg_ext == '0)
        begin
            win_cmp = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_WINDOW))
        begin
            win_cmp = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            win_cmp = cfg_ext;
        end
        win = win_cmp[WIN_W-1:0];
    end

    // An index left above a shrunken window wraps to 0 as well.
    assign idx_inc = WIN_W'(wr_idx_reg) + WIN_W'(1);
    assign idx_new = (idx_inc >= win) ? '0 : idx_inc[IDX_W-1:0];

    // Entries written since the last flood are slot 0 (once wrapped) and slots 1..fill_max;
    // every other slot still holds the flood value.
    assign ram_raddr     = (state_reg == ST_SWEEP) ? rd_cnt_reg[IDX_W-1:0] : idx_new;
    assign rd_valid_next = (ram_raddr == '0) ? zero_wr_reg : (ram_raddr <= fill_max_reg);
    assign mem_val       = rd_valid_reg ? ram_rdata : flood_reg;
    assign mem_ext       = SUM_W'(signed'(mem_val));
    assign smp_ext       = SUM_W'(signed'(sample_reg));

    assign ram_we    = (in_accept && s_axis_tuser && dirty_reg) || (state_reg == ST_UPDATE);
    assign ram_waddr = (state_reg == ST_UPDATE) ? wr_idx_reg : idx_new;
    assign ram_wdata = (state_reg == ST_UPDATE) ? sample_reg : in_sample;

    always_comb
    begin
        state_next     = state_reg;
        win_len_next   = cfg_we ? cfg_wdata : win_len_reg;
        wr_idx_next    = wr_idx_reg;
        fill_max_next  = fill_max_reg;
        zero_wr_next   = zero_wr_reg;
        flood_next     = flood_reg;
        dirty_next     = dirty_reg || cfg_we;
        sum_next       = sum_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = 1'b0;
        div_start_next = 1'b0;
        res_next       = res_reg;
        sample_next    = sample_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;

        if (ram_we)
        begin
            if (ram_waddr == '0)
            begin
                zero_wr_next = 1'b1;
            end
            else if (ram_waddr > fill_max_reg)
            begin
                fill_max_next = ram_waddr;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = in_sample;
                    if (!s_axis_tuser)
                    begin
                        flood_next    = in_sample;
                        fill_max_next = '0;
                        zero_wr_next  = 1'b0;
                        wr_idx_next   = '0;
                        dirty_next    = 1'b1;
                        res_next      = in_sample;
                        state_next    = ST_DONE;
                    end
                    else if (dirty_reg)
                    begin
                        wr_idx_next = idx_new;
                        sum_next    = '0;
                        rd_cnt_next = '0;
                        state_next  = ST_SWEEP;
                    end
                    else
                    begin
                        wr_idx_next = idx_new;
                        state_next  = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                // Old slot value arrives here; replace it in the running sum.
                sum_next       = sum_reg + smp_ext - mem_ext;
                div_start_next = 1'b1;
                state_next     = ST_DIVIDE;
            end
            ST_SWEEP:
            begin
                if (rd_cnt_reg < win)
                begin
                    rd_cnt_next  = rd_cnt_reg + WIN_W'(1);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    sum_next = sum_reg + mem_ext;
                end
                else if (rd_cnt_reg >= win)
                begin
                    dirty_next     = cfg_we;
                    div_start_next = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_len_reg   <= WINDOW_RESET;
            wr_idx_reg    <= '0;
            fill_max_reg  <= '0;
            zero_wr_reg   <= 1'b0;
            flood_reg     <= '0;
            dirty_reg     <= 1'b0;
            sum_reg       <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_len_reg   <= win_len_next;
            wr_idx_reg    <= wr_idx_next;
            fill_max_reg  <= fill_max_next;
            zero_wr_reg   <= zero_wr_next;
            flood_reg     <= flood_next;
            dirty_reg     <= dirty_next;
            sum_reg       <= sum_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= rd_valid_next;
        res_reg      <= res_next;
        sample_reg   <= sample_next;
        m_data_reg   <= m_data_next;
    end

    mawf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mawf_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (WIN_W),
        .QUOT_W     (SAMPLE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .divisor  (win),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_W'(m_data_reg);

    // In the update state the slot is written only now, so the fill mark catches up in the next cycle.
    a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_UPDATE) |-> ((wr_idx_reg == '0) || (wr_idx_reg <= fill_max_reg)))
        else $error("write index beyond the filled region");

    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !ram_we)
        else $error("sample memory written during window sweep");

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider result outside divide state");

    a_flood_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !s_axis_tuser) |=> (state_reg == ST_DONE) && dirty_reg)
        else $error("pass-through item did not go straight to output");

    a_start_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> (state_reg == ST_DIVIDE) && $past(state_reg != ST_DIVIDE))
        else $error("divider start not on entry to divide state");

endmodule

// File: design/mawf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mawf_ram #(
    parameter int WIDTH = mawf_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEPTH = mawf_pkg::MAX_WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import mawf_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mawf_div.sv
// Bit-serial signed-by-unsigned divider, truncating toward zero.
`timescale 1ns / 1ps

module mawf_div #(
    parameter int DIVIDEND_W = mawf_pkg::SAMPLE_WIDTH_DEF + 8,
    parameter int DIVISOR_W  = 8,
    parameter int QUOT_W     = mawf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         done,
    output logic signed [QUOT_W-1:0]     quotient
);
    import mawf_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                    busy_reg,  busy_next;
    logic                    done_reg,  done_next;
    logic [CNT_W-1:0]        cnt_reg,   cnt_next;
    logic [DIVIDEND_W-1:0]   mag_reg,   mag_next;
    logic [DIVISOR_W-1:0]    rem_reg,   rem_next;
    logic [DIVISOR_W-1:0]    dsr_reg,   dsr_next;
    logic                    neg_reg,   neg_next;
    logic [QUOT_W-1:0]       quot_reg,  quot_next;

    logic [DIVISOR_W:0]      trial;
    logic [DIVISOR_W:0]      diff;
    logic                    qbit;
    logic [DIVIDEND_W-1:0]   mag_step;
    logic [DIVIDEND_W-1:0]   signed_q;

    // One quotient bit per cycle: shift the dividend magnitude into the
    // remainder and subtract the divisor where it fits.
    always_comb
    begin
        trial    = {rem_reg, mag_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        qbit     = (trial >= {1'b0, dsr_reg});
        mag_step = {mag_reg[DIVIDEND_W-2:0], qbit};
        signed_q = neg_reg ? (~mag_step + DIVIDEND_W'(1)) : mag_step;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            neg_next  = dividend[DIVIDEND_W-1];
            mag_next  = dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1)) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            mag_next = mag_step;
            rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = signed_q[QUOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start) |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

endmodule

// File: tb/tb_moving_average_window_filter_core.sv
// Self-checking testbench for the moving-average window filter core.
`timescale 1ns / 1ps

module tb_moving_average_window_filter_core;

    import mawf_pkg::*;

    localparam int SW   = SAMPLE_WIDTH_DEF;
    localparam int MAXW = MAX_WINDOW_DEF;
    localparam int DW   = ((SW + 7) / 8) * 8;
    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 500;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 enable;
    } filter_item_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic          cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Predictor state: sample store, write slot and the raw window register.
    logic signed [SW-1:0] win_store [MAXW];
    int                   wr_slot;
    logic [CFG_W-1:0]     window_reg;

    filter_item_t         pending_items [$];
    logic [SW-1:0]        avg_expected [$];

    int  src_gap = 0;
    int  snk_gap = 0;
    int  hold_cycles = 0;
    bit  in_taken = 1'b0;
    bit  sink_hold = 1'b0;
    bit  calm = 1'b0;
    int  n_items = 0;
    int  n_flood = 0;
    int  n_results = 0;
    int  n_settings = 0;
    int  n_errors = 0;

    moving_average_window_filter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("%0t: timeout, %0d results still expected", $realtime, avg_expected.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [SW-1:0] filter_step(logic signed [SW-1:0] smp, logic en);
        longint acc;
        int     w;
        if (!en)
        begin
            for (int i = 0; i < MAXW; i++)
                win_store[i] = smp;
            wr_slot = 0;
            return smp;
        end
        w = (window_reg == 0) ? 1 : ((window_reg > MAXW) ? MAXW : int'(window_reg));
        wr_slot++;
        // A window shrunk below the current slot also wraps to the first slot.
        if (wr_slot >= w)
            wr_slot = 0;
        win_store[wr_slot] = smp;
        acc = 0;
        for (int i = 0; i < w; i++)
            acc += win_store[i];
        acc = acc / longint'(w);
        return acc[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return {SW{1'b1}};
            3: return SW'($urandom_range(0, 2000) - 1000);
            default: return SW'($urandom());
        endcase
    endfunction

    task automatic queue_item(int smp, logic en);
        filter_item_t it;
        it.sample = SW'(smp);
        it.enable = en;
        pending_items.push_back(it);
    endtask

    // Returns once the input side is empty and every expected average has come back.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || avg_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_window(int value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        n_settings++;
    endtask

    // Source side.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                filter_item_t it;
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= '0 | DW'(unsigned'(it.sample));
                s_axis_tuser  <= it.enable;
                if (!calm && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 7);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side; a requested long hold is counted here so the core backs up and stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (sink_hold && hold_cycles < HOLD_CYCLES)
        begin
            hold_cycles++;
            m_axis_tready <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                snk_gap = $urandom_range(1, 7);
        end
    end

    // Monitor: checks results, predicts accepted items and tracks register writes.
    always @(posedge clk)
    begin
        logic [DW-1:0] exp_word;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (avg_expected.size() == 0)
                begin
                    $display("%0t: unexpected average, expected none, actual 0x%0h",
                             $realtime, m_axis_tdata);
                    n_errors++;
                end
                else
                begin
                    exp_word = '0;
                    exp_word[SW-1:0] = avg_expected.pop_front();
                    if (m_axis_tdata !== exp_word)
                    begin
                        $display("%0t: average mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                                 $realtime, $signed(exp_word[SW-1:0]), exp_word,
                                 $signed(m_axis_tdata[SW-1:0]), m_axis_tdata);
                        n_errors++;
                    end
                end
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_items++;
                if (!s_axis_tuser)
                    n_flood++;
                avg_expected.push_back(filter_step(s_axis_tdata[SW-1:0], s_axis_tuser));
            end
            if (cfg_we)
                window_reg = cfg_wdata;
        end
    end

    initial
    begin
        int win_plan [16];
        for (int i = 0; i < MAXW; i++)
            win_store[i] = '0;
        wr_slot    = 0;
        window_reg = WINDOW_RESET;
        win_plan = '{1, 2, 3, 5, 7, 16, 31, 64, 100, 127, 128, 200, 0, 255, 4, 9};
        win_plan[14] = $urandom_range(0, 255);
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset window of one.
        queue_item(SMP_MAX, 1'b1);
        queue_item(SMP_MIN, 1'b1);
        queue_item('0, 1'b1);
        queue_item(-1, 1'b1);
        queue_item(1, 1'b0);
        queue_item(SMP_MIN, 1'b0);
        queue_item(SMP_MAX, 1'b0);
        write_window(8'd0);
        @(posedge clk);
        queue_item(123, 1'b1);
        queue_item(-5, 1'b1);
        write_window(8'd8);
        @(posedge clk);
        queue_item(SMP_MAX, 1'b1);
        queue_item(SMP_MAX, 1'b1);
        queue_item(SMP_MIN, 1'b1);
        queue_item(-3, 1'b1);
        queue_item(SMP_MIN, 1'b1);
        queue_item(7, 1'b1);
        // Shrink the window below the current write slot.
        write_window(8'd3);
        @(posedge clk);
        queue_item(7, 1'b1);
        queue_item(-7, 1'b1);
        // A flood fills the whole store, which shows once the window grows to full size.
        write_window(8'd2);
        @(posedge clk);
        queue_item(SMP_MAX, 1'b0);
        queue_item(SMP_MAX, 1'b1);
        write_window(8'd255);
        @(posedge clk);
        queue_item(-1, 1'b1);
        queue_item(SMP_MIN, 1'b1);
        write_window(8'd129);
        @(posedge clk);
        queue_item(5, 1'b1);

        // Random part, one window setting per phase.
        for (int p = 0; p < 16; p++)
        begin
            write_window(win_plan[p]);
            @(posedge clk);
            if (p >= 14)
                calm = 1'b1;
            // Ask the sink for one long hold while this phase's items are offered.
            if (p == 2)
                sink_hold = 1'b1;
            for (int k = 0; k < 90; k++)
                queue_item(pick_sample(), $urandom_range(0, 9) != 0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (avg_expected.size() != 0)
            n_errors++;
        $display("Ran %0d items (%0d pass-through) over %0d window settings.",
                 n_items, n_flood, n_settings);
        $display("Checked %0d averages with %0d mismatches.", n_results, n_errors);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/mawf_pkg.sv
design/mawf_ram.sv
design/mawf_div.sv
design/moving_average_window_filter_core.sv
tb/tb_moving_average_window_filter_core.sv
